// ===== rtl/c3rgb_pkg.sv =====
package c3rgb_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4095;
  localparam int CHANNELS_DEF   = 3;

  // number of samples per pixel carried on the bus
  localparam int NCH  = 3;
  localparam int PXW  = 8 * NCH;

  // configuration register indexes
  localparam logic [2:0] REG_K0  = 3'd0;
  localparam logic [2:0] REG_K1  = 3'd1;
  localparam logic [2:0] REG_K2  = 3'd2;
  localparam logic [2:0] REG_DIV = 3'd3;
  localparam logic [2:0] REG_W   = 3'd4;
  localparam logic [2:0] REG_H   = 3'd5;

  // weighted sum range: 9 * 255 * 128 fits in 20 bits signed
  localparam int SUMW = 20;

  // positive sum and divisor handed to the divider
  typedef struct packed {
    logic [SUMW-2:0] num;
    logic [7:0]      den;
  } div_req_t;

endpackage

// ===== rtl/c3rgb_div.sv =====
// iterative restoring divider, one quotient bit a cycle, saturating to 255
module c3rgb_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  c3rgb_pkg::div_req_t  req,
  output logic                 done,
  output logic [7:0]           quo
);
  localparam int NW = c3rgb_pkg::SUMW - 1;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_r;
  logic [NW-1:0] q_r;
  logic [8:0]    rem_r;
  logic [7:0]    den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [9:0]    trial;

  assign trial = {rem_r, num_r[NW-1]} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= req.num;
        den_r  <= req.den;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        num_r <= num_r << 1;
        if (!trial[9]) begin
          rem_r <= trial[8:0];
          q_r   <= {q_r[NW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[7:0], num_r[NW-1]};
          q_r   <= {q_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // saturate the quotient
  assign quo = (|q_r[NW-1:8]) ? 8'hFF : q_r[7:0];
endmodule

// ===== rtl/conv3x3_rgb_filter.sv =====
// 3x3 convolution filter for a three-sample 8-bit pixel stream.
// in_tdata : {chan2, chan1, chan0} lowest bits first; in_tuser : {start_of_frame, kind}.
// kind 1 is a flush request that pushes a zero pixel to drain pending results.
// out_tdata: {out_chan2, out_chan1, out_chan0}; out_tlast marks the last pixel of a frame.
// cfg_index selects kernel_row0..2, divisor, frame_width, frame_height (0..5).
// Two rows are kept in a single-port-style line memory (read, then write back).
// Each request runs through these steps in order: read line memory, update window,
// decide on border, then per channel nine multiply-accumulate terms and, for a
// positive sum, a 19-step bit-serial divide. A border pixel skips the arithmetic and
// a request with no result ends after the border decision. A new request is taken
// only once the previous one is finished and its result, if any, moved to the output.
// Results lag the input by one row plus one pixel; a request yields at most one
// result. The result register holds while out_tready is low; the next request is
// still taken, but its result waits until the held one has left. Reset clears
// counters, window and configuration to the sharpen kernel, divisor 1, 640x480;
// line memory is not cleared since its contents are always written before use.
module conv3x3_rgb_filter #(
  parameter int MAX_WIDTH  = c3rgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c3rgb_pkg::MAX_HEIGHT_DEF,
  parameter int CHANNELS   = c3rgb_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // chan0, chan1, chan2
  input  logic [1:0]  in_tuser,   // kind, start_of_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_chan0, out_chan1, out_chan2
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = WW + HW;
  localparam int PXW = c3rgb_pkg::PXW;
  localparam int SW  = c3rgb_pkg::SUMW;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_CALC, S_MAC, S_DIV, S_OUT} st_t;

  // configuration
  logic [23:0] k_r [3];
  logic [7:0]  div_r;
  logic [11:0] fw_r, fh_r;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r[0] <= 24'h00FF00;
      k_r[1] <= 24'hFF05FF;
      k_r[2] <= 24'h00FF00;
      div_r  <= 8'd1;
      fw_r   <= 12'd640;
      fh_r   <= 12'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        c3rgb_pkg::REG_K0:  k_r[0] <= cfg_data;
        c3rgb_pkg::REG_K1:  k_r[1] <= cfg_data;
        c3rgb_pkg::REG_K2:  k_r[2] <= cfg_data;
        c3rgb_pkg::REG_DIV: div_r  <= cfg_data[7:0];
        c3rgb_pkg::REG_W:   fw_r   <= cfg_data[11:0];
        c3rgb_pkg::REG_H:   fh_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // clamp geometry
  always_comb begin
    if (fw_r < 12'd3) w_eff = WW'(3);
    else if ({20'd0, fw_r} > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(fw_r);
    if (fh_r < 12'd3) h_eff = HW'(3);
    else if ({20'd0, fh_r} > 32'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(fh_r);
  end

  // line memory: both rows in one word, read then written back
  logic [2*PXW-1:0] lmem [MAX_WIDTH];
  logic [2*PXW-1:0] lrd_r;
  logic             lwe;
  logic [CW-1:0]    laddr;
  logic [2*PXW-1:0] lwd;

  always_ff @(posedge clk) begin
    if (lwe) lmem[laddr] <= lwd;
    lrd_r <= lmem[laddr];
  end

  st_t st_r;
  logic [WW-1:0] col_r;
  logic [11:0]   row_r;
  logic [PW-1:0] opos_r;
  logic [WW-1:0] ocol_r;
  logic [HW-1:0] orow_r;
  logic [PXW-1:0] cur_r;
  logic [PXW-1:0] win_r [3][3];
  logic          started_r, last_r;
  logic [1:0]    ch_r;
  logic [1:0]    mi_r, mj_r;
  logic signed [SW-1:0] acc_r;
  logic [PXW-1:0] res_r;
  logic [WW-1:0] colc;
  logic [PW-1:0] npix;
  logic          sof_take;
  logic          out_load;

  logic div_start, div_done;
  logic [7:0] div_q;
  c3rgb_pkg::div_req_t div_req;

  c3rgb_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .req(div_req),
    .done(div_done), .quo(div_q)
  );

  // a start of frame request reads column zero of the line memory
  assign sof_take = (st_r == S_IDLE) && in_tvalid && !in_tuser[0] && in_tuser[1];
  assign out_load = (st_r == S_OUT) && (!out_tvalid || out_tready);

  assign npix  = PW'(w_eff) * PW'(h_eff);
  assign colc  = (col_r >= w_eff) ? '0 : col_r;
  assign laddr = sof_take ? '0 : colc[CW-1:0];
  assign lwe   = (st_r == S_READ);
  assign lwd   = {cur_r, lrd_r[2*PXW-1:PXW]};
  assign in_tready = (st_r == S_IDLE);
  assign div_req.num = acc_r[SW-2:0];
  assign div_req.den = (div_r == 8'd0) ? 8'd1 : div_r;
  assign div_start = (st_r == S_MAC) && (mi_r == 2'd3) && (acc_r > 0);

  // one multiply-accumulate term
  logic [7:0] msamp;
  logic signed [7:0] mcoef;
  logic signed [SW-1:0] mprod;
  always_comb begin
    msamp = win_r[mi_r[1:0] == 2'd3 ? 0 : mi_r][mj_r == 2'd3 ? 0 : mj_r][ch_r*8 +: 8];
    mcoef = k_r[mi_r == 2'd3 ? 0 : mi_r][(mj_r == 2'd3 ? 0 : mj_r)*8 +: 8];
    mprod = SW'($signed({1'b0, msamp}) * mcoef);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      col_r <= '0; row_r <= '0; opos_r <= '0; ocol_r <= '0; orow_r <= '0;
      out_tvalid <= 1'b0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win_r[i][j] <= '0;
    end else begin
      if (out_tvalid && out_tready && !out_load) out_tvalid <= 1'b0;
      case (st_r)
        // take a request, handle start of frame
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cur_r <= in_tuser[0] ? '0 : in_tdata;
            if (!in_tuser[0] && in_tuser[1]) begin
              col_r <= '0; row_r <= '0; opos_r <= '0; ocol_r <= '0; orow_r <= '0;
            end
            st_r <= S_READ;
          end
        end
        // line memory data arrives, shift window and advance position
        S_READ: begin
          for (int i = 0; i < 3; i++) begin
            win_r[i][0] <= win_r[i][1];
            win_r[i][1] <= win_r[i][2];
          end
          win_r[0][2] <= lrd_r[PXW-1:0];
          win_r[1][2] <= lrd_r[2*PXW-1:PXW];
          win_r[2][2] <= cur_r;
          started_r <= (row_r >= 12'd2) || (row_r == 12'd1 && colc >= WW'(1));
          if (colc + 1'b1 >= w_eff) begin
            col_r <= '0;
            if (row_r < 12'd4095) row_r <= row_r + 1'b1;
          end else col_r <= colc + 1'b1;
          st_r <= S_CALC;
        end
        // decide on output and border
        S_CALC: begin
          last_r   <= (opos_r == npix - 1'b1);
          ch_r <= '0; mi_r <= '0; mj_r <= '0; acc_r <= '0;
          if (!(started_r && (opos_r < npix))) st_r <= S_IDLE;
          else if ((orow_r == '0) || (orow_r == h_eff - 1'b1) ||
                   (ocol_r == '0) || (ocol_r == w_eff - 1'b1)) begin
            for (int c = 0; c < c3rgb_pkg::NCH; c++)
              res_r[c*8 +: 8] <= (c < CHANNELS) ? win_r[1][1][c*8 +: 8] : 8'd0;
            st_r <= S_OUT;
          end else st_r <= S_MAC;
        end
        // accumulate nine terms, then divide a positive sum; a sum that is not positive gives zero
        S_MAC: begin
          if (mi_r == 2'd3) begin
            if (acc_r > 0) st_r <= S_DIV;
            else begin
              res_r[ch_r*8 +: 8] <= 8'd0;
              if (ch_r == 2'(c3rgb_pkg::NCH - 1)) st_r <= S_OUT;
              else begin
                ch_r <= ch_r + 1'b1; mi_r <= '0; mj_r <= '0; acc_r <= '0;
              end
            end
          end else begin
            acc_r <= acc_r + mprod;
            if (mj_r == 2'd2) begin mj_r <= '0; mi_r <= mi_r + 1'b1; end
            else mj_r <= mj_r + 1'b1;
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_r[ch_r*8 +: 8] <= (32'(ch_r) < CHANNELS) ? div_q : 8'd0;
            if (ch_r == 2'(c3rgb_pkg::NCH - 1)) st_r <= S_OUT;
            else begin
              ch_r <= ch_r + 1'b1; mi_r <= '0; mj_r <= '0; acc_r <= '0;
              st_r <= S_MAC;
            end
          end
        end
        // present result once the output register is free, advance output position
        S_OUT: begin
          if (out_load) begin
            out_tvalid <= 1'b1;
            out_tdata  <= res_r;
            out_tlast  <= last_r;
            opos_r <= opos_r + 1'b1;
            if (ocol_r + 1'b1 >= w_eff) begin
              ocol_r <= '0;
              orow_r <= orow_r + 1'b1;
            end else ocol_r <= ocol_r + 1'b1;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
